### hw/rtl/msp_pkg.sv
`default_nettype none

package msp_pkg;

  // Beat field widths
  localparam int MODE_W   = 1;
  localparam int SID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Packed port widths
  localparam int IN_USER_W  = MODE_W + SID_W;
  localparam int IN_DATA_W  = DATA_W;
  localparam int OUT_USER_W = STATUS_W;
  localparam int OUT_DATA_W = ((SLOT_W + DATA_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
  localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_POP
  } msp_state_t;

endpackage

`default_nettype wire

### hw/rtl/msp_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// Read data holds while rd_en is low.
module msp_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 37
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/multi_stack_shared_pool_core.sv
// Push: ST_TOP registers the result, then ST_IDLE takes the next beat.
// Pop: ST_TOP reads the top slot, ST_POP registers the result, then ST_IDLE takes the next beat.
// Refused ops (pool full, empty stack, bad stack number) behave like a push.
// Rate is set by serial reads of the top-pointer RAM, then the slot RAM, one port each.
// Reset (rst_n low, synchronous) clears all stacks and rebuilds the free list 0..POOL_SIZE-1
// at once via a high-water mark; no clearing pass, first beat taken right after reset.
`default_nettype none

module multi_stack_shared_pool_core #(
  parameter int NUM_STACKS = 4,
  parameter int POOL_SIZE  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tuser: mode [0], stack_id [2:1]
  input  wire logic [msp_pkg::IN_USER_W-1:0]     in_tuser,
  // in_tdata: value [31:0]
  input  wire logic [msp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tuser: status [1:0]
  output logic      [msp_pkg::OUT_USER_W-1:0]    out_tuser,
  // out_tdata: slot [3:0], data_out [35:4], zero [39:36]
  output logic      [msp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);

  localparam int AW      = $clog2(POOL_SIZE);
  localparam int TW      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int WM_W    = $clog2(POOL_SIZE + 1);
  localparam int SID_EXT = (TW > msp_pkg::SID_W) ? TW : msp_pkg::SID_W;
  localparam int SLOT_EXT = (AW > msp_pkg::SLOT_W) ? AW : msp_pkg::SLOT_W;
  localparam int DW      = msp_pkg::DATA_W;
  localparam int LW      = 1 + AW;       // link: valid + index
  localparam int SW      = DW + LW;      // slot word: data, link
  localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

  // Input beat fields
  logic                          in_mode;
  logic [msp_pkg::SID_W-1:0]     in_sid;
  logic [SID_EXT-1:0]            in_sid_ext;
  logic [TW-1:0]                 in_top_addr;
  logic                          in_sid_ok;
  logic                          in_acc;

  assign in_mode     = in_tuser[0];
  assign in_sid      = in_tuser[2:1];
  assign in_sid_ext  = SID_EXT'(in_sid);
  assign in_top_addr = in_sid_ext[TW-1:0];
  assign in_sid_ok   = ({30'd0, in_sid} < 32'(NUM_STACKS));
  assign in_acc      = in_tvalid && in_tready;

  // Control and operand registers
  msp_pkg::msp_state_t state_r, state_nxt;
  logic                 pop_r, pop_nxt;
  logic                 sid_ok_r, sid_ok_nxt;
  logic [TW-1:0]        sid_r, sid_nxt;
  logic [DW-1:0]        value_r, value_nxt;
  logic                 free_vld_r, free_vld_nxt;
  logic [AW-1:0]        free_idx_r, free_idx_nxt;
  logic [WM_W-1:0]      wm_r, wm_nxt;
  logic [NUM_STACKS-1:0] top_set_r, top_set_nxt;
  logic                 top_set_q_r, top_set_q_nxt;
  logic [AW-1:0]        pop_idx_r, pop_idx_nxt;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic [msp_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [msp_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [DW-1:0]                 out_data_r, out_data_nxt;

  // RAM ports
  logic          slot_rd_en, slot_wr_en;
  logic [AW-1:0] slot_rd_addr, slot_wr_addr;
  logic [SW-1:0] slot_rd_data, slot_wr_data;
  logic          top_rd_en, top_wr_en;
  logic [TW-1:0] top_rd_addr, top_wr_addr;
  logic [LW-1:0] top_rd_data, top_wr_data;

  msp_ram #(
    .DEPTH (POOL_SIZE),
    .AW    (AW),
    .DW    (SW)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  msp_ram #(
    .DEPTH (NUM_STACKS),
    .AW    (TW),
    .DW    (LW)
  ) u_top_ram (
    .clk     (clk),
    .rd_en   (top_rd_en),
    .rd_addr (top_rd_addr),
    .rd_data (top_rd_data),
    .wr_en   (top_wr_en),
    .wr_addr (top_wr_addr),
    .wr_data (top_wr_data)
  );

  // Decoded read data
  logic                top_vld;
  logic [AW-1:0]       top_idx;
  logic                ram_link_vld;
  logic [AW-1:0]       ram_link_idx;
  logic [DW-1:0]       ram_data;
  logic                touched;
  logic                link_vld;
  logic [AW-1:0]       link_idx;
  logic                can_emit;
  logic [SLOT_EXT-1:0] slot_ext;

  assign top_vld      = top_set_q_r && top_rd_data[LW-1];
  assign top_idx      = top_rd_data[AW-1:0];
  assign ram_data     = slot_rd_data[SW-1:LW];
  assign ram_link_vld = slot_rd_data[LW-1];
  assign ram_link_idx = slot_rd_data[AW-1:0];

  // Slots at or above the mark were never written: their link is the reset chain
  assign touched  = (WM_W'(free_idx_r) < wm_r);
  assign link_vld = touched ? ram_link_vld : (free_idx_r != LAST_SLOT);
  assign link_idx = touched ? ram_link_idx :
                    ((free_idx_r != LAST_SLOT) ? (free_idx_r + AW'(1)) : '0);

  assign can_emit = !out_valid_r || out_tready;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msp_pkg::ST_IDLE;
      free_vld_r  <= 1'b1;
      free_idx_r  <= '0;
      wm_r        <= '0;
      top_set_r   <= '0;
      top_set_q_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_vld_r  <= free_vld_nxt;
      free_idx_r  <= free_idx_nxt;
      wm_r        <= wm_nxt;
      top_set_r   <= top_set_nxt;
      top_set_q_r <= top_set_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pop_r        <= pop_nxt;
    sid_ok_r     <= sid_ok_nxt;
    sid_r        <= sid_nxt;
    value_r      <= value_nxt;
    pop_idx_r    <= pop_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Sequencer: read top / free head, then read popped slot, then write back
  always_comb begin
    state_nxt      = state_r;
    pop_nxt        = pop_r;
    sid_ok_nxt     = sid_ok_r;
    sid_nxt        = sid_r;
    value_nxt      = value_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    wm_nxt         = wm_r;
    top_set_nxt    = top_set_r;
    top_set_q_nxt  = top_set_q_r;
    pop_idx_nxt    = pop_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_data_nxt   = out_data_r;
    in_tready      = 1'b0;
    slot_rd_en     = 1'b0;
    slot_rd_addr   = free_idx_r;
    slot_wr_en     = 1'b0;
    slot_wr_addr   = free_idx_r;
    slot_wr_data   = {value_r, top_vld, top_idx};
    top_rd_en      = 1'b0;
    top_rd_addr    = in_top_addr;
    top_wr_en      = 1'b0;
    top_wr_addr    = sid_r;
    top_wr_data    = {1'b1, free_idx_r};
    slot_ext       = SLOT_EXT'(free_idx_r);

    case (state_r)
      msp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          pop_nxt       = (in_mode == msp_pkg::MODE_POP);
          sid_ok_nxt    = in_sid_ok;
          sid_nxt       = in_top_addr;
          value_nxt     = in_tdata;
          top_set_q_nxt = in_sid_ok && top_set_r[in_top_addr];
          top_rd_en     = 1'b1;
          slot_rd_en    = 1'b1;
          state_nxt     = msp_pkg::ST_TOP;
        end
      end

      msp_pkg::ST_TOP: begin
        if (!pop_r) begin
          // Push: take free head, link it over the current top
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = msp_pkg::ST_IDLE;
            if (!sid_ok_r || !free_vld_r) begin
              out_status_nxt = msp_pkg::STAT_FULL;
              out_slot_nxt   = '0;
              out_data_nxt   = '0;
            end else begin
              slot_wr_en          = 1'b1;
              top_wr_en           = 1'b1;
              top_set_nxt[sid_r]  = 1'b1;
              free_vld_nxt        = link_vld;
              free_idx_nxt        = link_idx;
              if (!touched) begin
                wm_nxt = wm_r + WM_W'(1);
              end
              out_status_nxt = msp_pkg::STAT_DONE;
              out_slot_nxt   = slot_ext[msp_pkg::SLOT_W-1:0];
              out_data_nxt   = value_r;
            end
          end
        end else if (!sid_ok_r || !top_vld) begin
          // Pop of an empty or unknown stack
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = msp_pkg::STAT_EMPTY;
            out_slot_nxt   = '0;
            out_data_nxt   = '0;
            state_nxt      = msp_pkg::ST_IDLE;
          end
        end else begin
          // Pop: fetch the top slot's word
          slot_rd_en   = 1'b1;
          slot_rd_addr = top_idx;
          pop_idx_nxt  = top_idx;
          state_nxt    = msp_pkg::ST_POP;
        end
      end

      msp_pkg::ST_POP: begin
        slot_ext = SLOT_EXT'(pop_idx_r);
        if (can_emit) begin
          // Unlink top, push slot onto the free list
          top_wr_en      = 1'b1;
          top_wr_data    = {ram_link_vld, ram_link_idx};
          slot_wr_en     = 1'b1;
          slot_wr_addr   = pop_idx_r;
          slot_wr_data   = {ram_data, free_vld_r, free_idx_r};
          free_vld_nxt   = 1'b1;
          free_idx_nxt   = pop_idx_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = msp_pkg::STAT_DONE;
          out_slot_nxt   = slot_ext[msp_pkg::SLOT_W-1:0];
          out_data_nxt   = ram_data;
          state_nxt      = msp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = msp_pkg::ST_IDLE;
      end
    endcase
  end

  // Output beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(msp_pkg::OUT_DATA_W - DW - msp_pkg::SLOT_W){1'b0}},
                       out_data_r, out_slot_r};

endmodule

`default_nettype wire

### hw/rtl/msp_checker.sv
`default_nettype none

module msp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [msp_pkg::OUT_USER_W-1:0] out_tuser,
  input wire logic [msp_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // One op at a time: no beat taken right after another
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // Refused ops carry a zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != msp_pkg::STAT_DONE |-> out_tdata == '0)
    else $error("nonzero payload on error status");

  // Status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == msp_pkg::STAT_DONE || out_tuser == msp_pkg::STAT_FULL ||
                    out_tuser == msp_pkg::STAT_EMPTY))
    else $error("undefined status code");

endmodule

bind multi_stack_shared_pool_core msp_checker u_msp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### dv/msp_checker.sv
`timescale 1ns / 1ps

// Watches both channels, tracks the pool and stack pointers, and scores results in order.
module msp_scoreboard #(
  parameter int STACKS = 4,
  parameter int SLOTS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [msp_pkg::IN_USER_W-1:0]     in_tuser,
  input  wire logic [msp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic [msp_pkg::OUT_USER_W-1:0]    out_tuser,
  input  wire logic [msp_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  output int                                     mismatch_cnt,
  output int                                     pending_cnt,
  output int                                     full_hits,
  output int                                     empty_hits
);

  // Pointer: valid bit plus slot index
  typedef struct packed {
    logic                       ok;
    logic [msp_pkg::SLOT_W-1:0] idx;
  } slot_ptr_t;

  typedef struct packed {
    logic [msp_pkg::STATUS_W-1:0] status;
    logic [msp_pkg::SLOT_W-1:0]   slot;
    logic [msp_pkg::DATA_W-1:0]   data;
  } stack_result_t;

  logic [msp_pkg::DATA_W-1:0] word_mem  [SLOTS];
  slot_ptr_t                  next_link [SLOTS];
  slot_ptr_t                  top_ptr   [STACKS];
  slot_ptr_t                  free_ptr;
  stack_result_t              pending_results [$];

  // Applies one push or pop to the tracked pool and returns the result beat
  function automatic stack_result_t stack_pool_apply(
      input logic op,
      input logic [msp_pkg::SID_W-1:0] sid,
      input logic [msp_pkg::DATA_W-1:0] word);
    stack_result_t r;
    logic [msp_pkg::SLOT_W-1:0] s;
    r = '0;
    if (op == msp_pkg::MODE_PUSH) begin
      if (!free_ptr.ok) begin
        r.status = msp_pkg::STAT_FULL;
        return r;
      end
      s = free_ptr.idx;
      free_ptr = next_link[s];
      word_mem[s] = word;
      next_link[s] = top_ptr[sid];
      top_ptr[sid] = '{ok: 1'b1, idx: s};
      r.status = msp_pkg::STAT_DONE;
      r.slot = s;
      r.data = word;
    end else begin
      if (!top_ptr[sid].ok) begin
        r.status = msp_pkg::STAT_EMPTY;
        return r;
      end
      s = top_ptr[sid].idx;
      top_ptr[sid] = next_link[s];
      next_link[s] = free_ptr;
      free_ptr = '{ok: 1'b1, idx: s};
      r.status = msp_pkg::STAT_DONE;
      r.slot = s;
      r.data = word_mem[s];
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    stack_result_t exp_r;
    stack_result_t got_r;
    if (!rst_n) begin
      // free list 0 -> 1 -> ... -> last, all stacks empty
      for (int i = 0; i < SLOTS; i++) begin
        word_mem[i] = '0;
        if (i + 1 < SLOTS) next_link[i] = '{ok: 1'b1, idx: msp_pkg::SLOT_W'(i + 1)};
        else next_link[i] = '0;
      end
      for (int i = 0; i < STACKS; i++) top_ptr[i] = '0;
      free_ptr = '{ok: 1'b1, idx: '0};
      pending_results.delete();
      pending_cnt <= 0;
    end else begin
      // input beat: predict its result
      if (in_tvalid && in_tready) begin
        pending_results.push_back(stack_pool_apply(in_tuser[0],
                                                   in_tuser[msp_pkg::MODE_W +: msp_pkg::SID_W],
                                                   in_tdata));
      end
      // output beat: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got_r.status = out_tuser;
        got_r.slot   = out_tdata[msp_pkg::SLOT_W-1:0];
        got_r.data   = out_tdata[msp_pkg::SLOT_W +: msp_pkg::DATA_W];
        if (got_r.status == msp_pkg::STAT_FULL) full_hits++;
        if (got_r.status == msp_pkg::STAT_EMPTY) empty_hits++;
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] unexpected result beat: status %0d slot %0d data %h",
                     $realtime, got_r.status, got_r.slot, got_r.data);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.status != got_r.status || exp_r.slot != got_r.slot ||
              exp_r.data != got_r.data) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("[%0t] result mismatch: status %0d/%0d slot %0d/%0d data %h/%h %s",
                       $realtime, exp_r.status, got_r.status, exp_r.slot, got_r.slot,
                       exp_r.data, got_r.data, "(expected/actual)");
          end
        end
      end
      pending_cnt <= pending_results.size();
    end
  end

  initial begin
    mismatch_cnt = 0;
    full_hits = 0;
    empty_hits = 0;
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STACKS     = 4;
  localparam int SLOTS      = 16;
  localparam int N_RANDOM   = 1126;
  localparam int LONG_HOLD  = 400;
  localparam int STALL_LIMIT = 3000;

  logic                              clk;
  logic                              rst_n;
  logic [msp_pkg::IN_USER_W-1:0]     in_tuser;
  logic [msp_pkg::IN_DATA_W-1:0]     in_tdata;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [msp_pkg::OUT_USER_W-1:0]    out_tuser;
  logic [msp_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic                              out_tvalid;
  logic                              out_tready;

  int mismatch_cnt;
  int pending_cnt;
  int full_hits;
  int empty_hits;
  int n_push;
  int n_pop;

  bit send_gaps;
  bit sink_stalls;
  bit hold_req;

  multi_stack_shared_pool_core #(
    .NUM_STACKS(STACKS),
    .POOL_SIZE (SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  msp_scoreboard #(
    .STACKS(STACKS),
    .SLOTS (SLOTS)
  ) u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .mismatch_cnt(mismatch_cnt),
    .pending_cnt (pending_cnt),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Data word with extra weight on the sign and all-ones/all-zeros patterns
  function automatic logic [msp_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat, optionally after a random gap, and hold it until taken
  task automatic send_beat(input logic op, input logic [msp_pkg::SID_W-1:0] sid,
                           input logic [msp_pkg::DATA_W-1:0] word);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sid, op};
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (op == msp_pkg::MODE_PUSH) n_push++;
    else n_pop++;
  endtask

  // Stop offering and wait for every predicted result to come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        n = LONG_HOLD;
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 17);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 24);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int push_pct;
    logic [msp_pkg::SID_W-1:0] sid;
    logic op;

    n_push = 0;
    n_pop = 0;
    send_gaps = 1'b1;
    sink_stalls = 1'b1;
    hold_req = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, extreme words, LIFO order, pool exhaustion
    send_beat(msp_pkg::MODE_POP,  2'd0, 32'hFFFF_FFFF);
    send_beat(msp_pkg::MODE_POP,  2'd3, 32'h1234_5678);
    send_beat(msp_pkg::MODE_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_beat(msp_pkg::MODE_PUSH, 2'd0, 32'h8000_0000);
    send_beat(msp_pkg::MODE_PUSH, 2'd1, 32'h0000_0000);
    send_beat(msp_pkg::MODE_PUSH, 2'd2, 32'hFFFF_FFFF);
    send_beat(msp_pkg::MODE_PUSH, 2'd3, 32'hAAAA_AAAA);
    send_beat(msp_pkg::MODE_POP,  2'd0, 32'h5555_5555);
    send_beat(msp_pkg::MODE_POP,  2'd0, 32'h0000_0000);
    send_beat(msp_pkg::MODE_POP,  2'd0, 32'hFFFF_FFFF);
    for (int i = 0; i < SLOTS - 3; i++)
      send_beat(msp_pkg::MODE_PUSH, msp_pkg::SID_W'(i),
                (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
    send_beat(msp_pkg::MODE_PUSH, 2'd1, 32'h7FFF_FFFF);
    send_beat(msp_pkg::MODE_PUSH, 2'd3, 32'h8000_0000);

    // Random: phases that drain, mix and fill the pool
    for (int k = 0; k < N_RANDOM; k++) begin
      case ((k / 80) % 3)
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 75;
      endcase
      // long receiver hold while the sender keeps offering back to back
      if (k == 300) begin
        send_gaps = 1'b0;
        hold_req = 1'b1;
      end
      if (k == 380) send_gaps = 1'b1;
      // sender pause until all results are back
      if (k == 600) wait_drained();
      if (k == N_RANDOM - 150) begin
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      op  = ($urandom_range(0, 99) < push_pct) ? msp_pkg::MODE_PUSH : msp_pkg::MODE_POP;
      sid = msp_pkg::SID_W'($urandom_range(0, STACKS - 1));
      send_beat(op, sid, pick_word());
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d pushes and %0d pops over %0d stacks sharing %0d slots",
             n_push, n_pop, STACKS, SLOTS);
    $display("pool-full refusals: %0d, empty-stack refusals: %0d, mismatches: %0d",
             full_hits, empty_hits, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_ram.sv
hw/rtl/multi_stack_shared_pool_core.sv
hw/rtl/msp_checker.sv
dv/msp_checker.sv
dv/tb_top.sv
